/* rtl/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants for the LRU sector cache.
// ----------------------------------------------------------------------------
package lsc_pkg;

    // Fixed field widths
    localparam int TRACK_W     = 16;
    localparam int SECTOR_W    = 16;
    localparam int WORD_W      = 64;
    localparam int STATUS_W    = 3;
    localparam int LINE_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int LC_W        = 5;

    // Stream packing
    localparam int S_TDATA_W   = 96;  // track, sector, payload_in
    localparam int M_TDATA_W   = 80;  // line, payload_out, item_count, zero pad
    localparam int M_PAD_W     = M_TDATA_W - LINE_W - WORD_W - COUNT_W;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT = '0;
    localparam logic [LC_W-1:0]      LINE_COUNT_RESET = 5'd16;

    localparam logic ACTION_GET = 1'b0;
    localparam logic ACTION_PUT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GET_HIT  = 3'd0,
        ST_GET_MISS = 3'd1,
        ST_PUT_UPD  = 3'd2,
        ST_PUT_FILL = 3'd3,
        ST_PUT_REPL = 3'd4
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the incoming item
        logic eval;    // tag compare and victim select, latch decision
        logic commit;  // apply update, load output register
    } lsc_cmd_t;

endpackage

/* rtl/lsc_cfg.sv */
// ----------------------------------------------------------------------------
// lsc_cfg
// APB register block holding line_count; a write to it flushes the cache.
// ----------------------------------------------------------------------------
module lsc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [lsc_pkg::LC_W-1:0]        line_count,
    output logic                            flush
);
    import lsc_pkg::*;

    logic [LC_W-1:0]      line_count_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_line_count;

    assign pready        = 1'b1;
    assign reg_idx       = paddr[APB_ADDR_W-1:2];
    assign wr_line_count = psel && penable && pwrite && pready && (reg_idx == REG_LINE_COUNT);
    assign flush         = wr_line_count;
    assign line_count    = line_count_reg;

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_LINE_COUNT)
        begin
            prdata = APB_DATA_W'(line_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINE_COUNT_RESET;
        end
        else if (wr_line_count)
        begin
            line_count_reg <= pwdata[LC_W-1:0];
        end
    end

endmodule

/* rtl/lsc_ctrl.sv */
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: accept, evaluate, write back; owns the output valid.
// ----------------------------------------------------------------------------
module lsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lsc_pkg::lsc_cmd_t cmd
);
    import lsc_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        EVAL,
        WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   load_ok;
    logic   accept;

    // output slot can take a new result this cycle
    assign load_ok  = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == IDLE) || ((state_reg == WRITE) && load_ok);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    assign cmd.load   = accept;
    assign cmd.eval   = (state_reg == EVAL);
    assign cmd.commit = (state_reg == WRITE) && load_ok;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    state_next = EVAL;
                end
            end
            EVAL:
            begin
                state_next = WRITE;
            end
            WRITE:
            begin
                if (load_ok)
                begin
                    state_next = accept ? EVAL : IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == EVAL))
        else $error("accepted transfer did not start evaluation");

    a_eval_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EVAL) |=> (state_reg == WRITE))
        else $error("evaluation not followed by write back");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !cmd.commit ##1 m_tvalid)
        else $error("pending result overwritten");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("output valid without a commit");

endmodule

/* rtl/lsc_datapath.sv */
// ----------------------------------------------------------------------------
// lsc_datapath
// Tag array, recency ranks, payload store, decision and output registers.
// ----------------------------------------------------------------------------
module lsc_datapath #(
    parameter int MAX_LINES  = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsc_pkg::lsc_cmd_t             cmd,
    input  logic                          flush,
    input  logic [lsc_pkg::LC_W-1:0]      line_count,
    input  logic                          in_action,
    input  logic [lsc_pkg::TRACK_W-1:0]   in_track,
    input  logic [lsc_pkg::SECTOR_W-1:0]  in_sector,
    input  logic [lsc_pkg::WORD_W-1:0]    in_payload,
    output logic [lsc_pkg::STATUS_W-1:0]  out_status,
    output logic [lsc_pkg::LINE_W-1:0]    out_line,
    output logic [lsc_pkg::WORD_W-1:0]    out_payload,
    output logic [lsc_pkg::COUNT_W-1:0]   out_count
);
    import lsc_pkg::*;

    localparam int IDX_W = $clog2(MAX_LINES);
    localparam int CNT_W = $clog2(MAX_LINES + 1);

    // captured item
    logic                  act_reg;
    logic [TRACK_W-1:0]    trk_reg;
    logic [SECTOR_W-1:0]   sct_reg;
    logic [DATA_WIDTH-1:0] dat_reg;

    // cache state
    logic [TRACK_W-1:0]    tag_track_reg  [MAX_LINES];
    logic [SECTOR_W-1:0]   tag_sector_reg [MAX_LINES];
    logic [DATA_WIDTH-1:0] payload_reg    [MAX_LINES];
    logic [MAX_LINES-1:0]  valid_reg;
    logic [IDX_W-1:0]      rank_reg       [MAX_LINES];
    logic [CNT_W-1:0]      total_reg;

    // decision
    status_t               dec_status_reg;
    logic [IDX_W-1:0]      dec_idx_reg;
    logic [IDX_W-1:0]      dec_rank_reg;
    logic [DATA_WIDTH-1:0] dec_data_reg;

    // output register
    status_t               out_status_reg;
    logic [LINE_W-1:0]     out_line_reg;
    logic [WORD_W-1:0]     out_payload_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    logic [CNT_W-1:0]      n_lines;
    logic [IDX_W-1:0]      last_rank;
    logic [MAX_LINES-1:0]  active, match, free, lru;
    logic [IDX_W-1:0]      hit_idx, free_idx, lru_idx;
    status_t               eval_status;
    logic [IDX_W-1:0]      eval_idx;
    logic                  is_put, is_touch;
    logic [CNT_W-1:0]      total_next;

    // active line count: zero acts as one, clamp to the built size
    always_comb
    begin
        if (line_count == '0)
        begin
            n_lines = CNT_W'(1);
        end
        else if (32'(line_count) > MAX_LINES)
        begin
            n_lines = CNT_W'(MAX_LINES);
        end
        else
        begin
            n_lines = CNT_W'(line_count);
        end
    end

    assign last_rank = IDX_W'(n_lines - CNT_W'(1));

    always_comb
    begin
        for (int j = 0; j < MAX_LINES; j++)
        begin
            active[j] = 32'(j) < 32'(n_lines);
            match[j]  = valid_reg[j] && active[j]
                        && (tag_track_reg[j] == trk_reg) && (tag_sector_reg[j] == sct_reg);
            free[j]   = !valid_reg[j] && active[j];
            // all active lines are valid when this is used: ranks are a permutation
            lru[j]    = valid_reg[j] && active[j] && (rank_reg[j] == last_rank);
        end
    end

    // lowest-index priority encoders
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int j = MAX_LINES - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                hit_idx = IDX_W'(j);
            end
            if (free[j])
            begin
                free_idx = IDX_W'(j);
            end
            if (lru[j])
            begin
                lru_idx = IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        if (act_reg == ACTION_GET)
        begin
            eval_status = (|match) ? ST_GET_HIT : ST_GET_MISS;
            eval_idx    = (|match) ? hit_idx : '0;
        end
        else if (|match)
        begin
            eval_status = ST_PUT_UPD;
            eval_idx    = hit_idx;
        end
        else if (|free)
        begin
            eval_status = ST_PUT_FILL;
            eval_idx    = free_idx;
        end
        else
        begin
            eval_status = ST_PUT_REPL;
            eval_idx    = lru_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_action;
            trk_reg <= in_track;
            sct_reg <= in_sector;
            dat_reg <= in_payload[DATA_WIDTH-1:0];
        end
        if (cmd.eval)
        begin
            dec_status_reg <= eval_status;
            dec_idx_reg    <= eval_idx;
            dec_rank_reg   <= rank_reg[eval_idx];
            dec_data_reg   <= payload_reg[eval_idx];
        end
    end

    assign is_put   = (dec_status_reg == ST_PUT_UPD) || (dec_status_reg == ST_PUT_FILL)
                      || (dec_status_reg == ST_PUT_REPL);
    assign is_touch = (dec_status_reg == ST_GET_HIT) || (dec_status_reg == ST_PUT_UPD)
                      || (dec_status_reg == ST_PUT_REPL);
    assign total_next = (dec_status_reg == ST_PUT_FILL) ? total_reg + CNT_W'(1) : total_reg;

    // tags and payloads: no reset, reachable only through valid lines
    always_ff @(posedge clk)
    begin
        if (cmd.commit && is_put)
        begin
            payload_reg[dec_idx_reg] <= dat_reg;
            if (dec_status_reg != ST_PUT_UPD)
            begin
                tag_track_reg[dec_idx_reg]  <= trk_reg;
                tag_sector_reg[dec_idx_reg] <= sct_reg;
            end
        end
        if (cmd.commit)
        begin
            out_status_reg  <= dec_status_reg;
            out_line_reg    <= LINE_W'(dec_idx_reg);
            out_payload_reg <= (dec_status_reg == ST_GET_HIT) ? WORD_W'(dec_data_reg) : '0;
            out_count_reg   <= COUNT_W'(total_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            for (int j = 0; j < MAX_LINES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else if (flush)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            for (int j = 0; j < MAX_LINES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            total_reg <= total_next;
            for (int j = 0; j < MAX_LINES; j++)
            begin
                if (IDX_W'(j) == dec_idx_reg && (is_touch || dec_status_reg == ST_PUT_FILL))
                begin
                    rank_reg[j] <= '0;
                end
                else if (is_touch && valid_reg[j] && active[j] && rank_reg[j] < dec_rank_reg)
                begin
                    rank_reg[j] <= rank_reg[j] + IDX_W'(1);
                end
                else if (dec_status_reg == ST_PUT_FILL && valid_reg[j] && active[j])
                begin
                    rank_reg[j] <= rank_reg[j] + IDX_W'(1);
                end
            end
            if (dec_status_reg == ST_PUT_FILL)
            begin
                valid_reg[dec_idx_reg] <= 1'b1;
            end
        end
    end

    assign out_status  = out_status_reg;
    assign out_line    = out_line_reg;
    assign out_payload = out_payload_reg;
    assign out_count   = out_count_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(total_reg))
        else $error("valid line count out of step with valid bits");

    a_fill_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && dec_status_reg == ST_PUT_FILL) |-> !valid_reg[dec_idx_reg])
        else $error("fill targets a valid line");

endmodule

/* rtl/lru_sector_cache.sv */
// A result is offered once the accepted item has passed the evaluate and
// write-back states: tag compare and victim select in evaluate, write back of
// tags, ranks and payload in write back. The next item can be accepted in the
// same cycle that write back commits; output stalls hold the write back and intake.
// Reset (rst_n, async): all lines invalid, ranks and count zero, line_count 16;
// tags and payloads are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// lru_sector_cache
// Fully associative track/sector cache with LRU replacement.
// ----------------------------------------------------------------------------
module lru_sector_cache #(
    parameter int MAX_LINES  = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsc_pkg::S_TDATA_W-1:0]   s_tdata,   // track, sector, payload_in
    input  logic                            s_tuser,   // action
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsc_pkg::M_TDATA_W-1:0]   m_tdata,   // line, payload_out, item_count, pad
    output logic [lsc_pkg::STATUS_W-1:0]    m_tuser    // status
);
    import lsc_pkg::*;

    lsc_cmd_t             cmd;
    logic                 flush;
    logic [LC_W-1:0]      line_count;
    logic [LINE_W-1:0]    out_line;
    logic [WORD_W-1:0]    out_payload;
    logic [COUNT_W-1:0]   out_count;

    lsc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .line_count (line_count),
        .flush      (flush)
    );

    lsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lsc_datapath #(
        .MAX_LINES  (MAX_LINES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flush       (flush),
        .line_count  (line_count),
        .in_action   (s_tuser),
        .in_track    (s_tdata[TRACK_W-1:0]),
        .in_sector   (s_tdata[TRACK_W+SECTOR_W-1:TRACK_W]),
        .in_payload  (s_tdata[S_TDATA_W-1:TRACK_W+SECTOR_W]),
        .out_status  (m_tuser),
        .out_line    (out_line),
        .out_payload (out_payload),
        .out_count   (out_count)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_count, out_payload, out_line};

endmodule

/* test/tb_lru_sector_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_sector_cache
// Self-checking bench for the LRU sector cache. A directed table covers reset
// state, key and payload extremes, every status code and the line-count corner
// cases. Random phases follow, each under a new line-count setting, with keys
// mostly drawn from a small pool so that hits, updates and LRU replacements are
// frequent. Every result is checked against its table entry or an in-bench cache model.
// ----------------------------------------------------------------------------
module tb_lru_sector_cache;
    import lsc_pkg::*;

    localparam int LINES          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 18;
    localparam int PHASE_ITEMS    = 108;

    localparam logic [APB_ADDR_W-1:0] ADDR_LINE_COUNT = {REG_LINE_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

    typedef struct packed {
        logic                action;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [WORD_W-1:0]   payload;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [LINE_W-1:0]   line;
        logic [WORD_W-1:0]   payload;
        logic [COUNT_W-1:0]  count;
    } lookup_t;

    typedef enum { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [APB_ADDR_W-1:0]   addr;
        logic [APB_DATA_W-1:0]   value;
        request_t                req;
        bit                      typed;
        lookup_t                 res;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // track, sector, payload_in
    logic                   s_tuser;   // action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // line, payload_out, item_count, pad
    logic [STATUS_W-1:0]    m_tuser;   // status

    lru_sector_cache u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the cache contents
    logic [TRACK_W-1:0]  sh_track  [LINES];
    logic [SECTOR_W-1:0] sh_sector [LINES];
    bit                  sh_valid  [LINES];
    int unsigned         sh_rank   [LINES];
    logic [WORD_W-1:0]   sh_word   [LINES];
    int unsigned         sh_total;
    logic [LC_W-1:0]     sh_line_count;

    lookup_t pending_results [$];
    row_t    dir_rows [$];

    int errors        = 0;
    int requests_sent = 0;
    int settings_seen = 0;
    int stall_cycles  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int send_idle_pct = 21;
    int recv_idle_pct = 58;
    int n_hit = 0, n_miss = 0, n_upd = 0, n_fill = 0, n_repl = 0;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned active_count(input logic [LC_W-1:0] lc);
        return (lc == 0) ? 1 : ((lc > LINES) ? LINES : lc);
    endfunction

    function automatic void clear_shadow();
        for (int j = 0; j < LINES; j++)
        begin
            sh_valid[j] = 1'b0;
            sh_rank[j]  = 0;
        end
        sh_total = 0;
    endfunction

    // Move a valid line to rank 0, aging the lines that were ahead of it
    function automatic void promote(input int unsigned idx, input int unsigned n);
        int unsigned old;
        old = sh_rank[idx];
        for (int unsigned j = 0; j < n; j++)
            if (sh_valid[j] && sh_rank[j] < old)
                sh_rank[j]++;
        sh_rank[idx] = 0;
    endfunction

    function automatic lookup_t lookup_update(input request_t r);
        int unsigned n;
        int unsigned idx;
        bit          hit;
        bit          got_free;
        lookup_t     res;
        n        = active_count(sh_line_count);
        idx      = 0;
        hit      = 1'b0;
        got_free = 1'b0;
        res.payload = '0;
        for (int unsigned j = 0; j < n; j++)
            if (!hit && sh_valid[j] && sh_track[j] == r.track && sh_sector[j] == r.sector)
            begin
                hit = 1'b1;
                idx = j;
            end
        if (r.action == ACTION_GET)
        begin
            if (hit)
            begin
                res.status  = ST_GET_HIT;
                res.payload = sh_word[idx];
                promote(idx, n);
            end
            else
            begin
                res.status = ST_GET_MISS;
                idx = 0;
            end
        end
        else if (hit)
        begin
            res.status   = ST_PUT_UPD;
            sh_word[idx] = r.payload;
            promote(idx, n);
        end
        else
        begin
            for (int unsigned j = 0; j < n; j++)
                if (!got_free && !sh_valid[j])
                begin
                    got_free = 1'b1;
                    idx = j;
                end
            if (got_free)
            begin
                res.status = ST_PUT_FILL;
                for (int unsigned j = 0; j < n; j++)
                    if (sh_valid[j])
                        sh_rank[j]++;
                sh_valid[idx] = 1'b1;
                sh_rank[idx]  = 0;
                sh_total++;
            end
            else
            begin
                // all active lines valid: victim is the highest rank, lowest index on ties
                res.status = ST_PUT_REPL;
                idx = 0;
                for (int unsigned j = 1; j < n; j++)
                    if (sh_rank[j] > sh_rank[idx])
                        idx = j;
                promote(idx, n);
            end
            sh_track[idx]  = r.track;
            sh_sector[idx] = r.sector;
            sh_word[idx]   = r.payload;
        end
        res.line  = idx[LINE_W-1:0];
        res.count = sh_total[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void apply_config(input logic [APB_ADDR_W-1:0] addr,
                                         input logic [APB_DATA_W-1:0] value);
        if (addr[APB_ADDR_W-1:2] == REG_LINE_COUNT)
        begin
            sh_line_count = value[LC_W-1:0];
            clear_shadow();
        end
    endfunction

    function automatic void add_req(input logic act, input logic [15:0] trk,
                                    input logic [15:0] sec, input logic [63:0] pay);
        row_t r;
        r.kind  = ROW_REQ;
        r.req   = {act, trk, sec, pay};
        r.typed = 1'b0;
        r.res   = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_checked(input logic act, input logic [15:0] trk,
                                        input logic [15:0] sec, input logic [63:0] pay,
                                        input status_t st, input logic [3:0] ln,
                                        input logic [63:0] pout, input logic [4:0] cnt);
        row_t r;
        r.kind  = ROW_REQ;
        r.req   = {act, trk, sec, pay};
        r.typed = 1'b1;
        r.res   = {st, ln, pout, cnt};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [APB_ADDR_W-1:0] addr,
                                    input logic [APB_DATA_W-1:0] value);
        row_t r;
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.value = value;
        r.typed = 1'b0;
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input request_t r, input bit typed, input lookup_t typed_res);
        lookup_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.action;
        s_tdata  <= {r.payload, r.sector, r.track};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = lookup_update(r);
        pending_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_config(addr, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", 64'(m_tuser), 64'(0));
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[LINE_W-1:0] !== want.line)
                    report_mismatch("line", 64'(m_tdata[LINE_W-1:0]), 64'(want.line));
                if (m_tdata[LINE_W+WORD_W-1:LINE_W] !== want.payload)
                    report_mismatch("payload_out", m_tdata[LINE_W+WORD_W-1:LINE_W],
                                    want.payload);
                if (m_tdata[LINE_W+WORD_W+COUNT_W-1:LINE_W+WORD_W] !== want.count)
                    report_mismatch("item_count",
                                    64'(m_tdata[LINE_W+WORD_W+COUNT_W-1:LINE_W+WORD_W]),
                                    64'(want.count));
                case (want.status)
                    ST_GET_HIT:  n_hit++;
                    ST_GET_MISS: n_miss++;
                    ST_PUT_UPD:  n_upd++;
                    ST_PUT_FILL: n_fill++;
                    default:     n_repl++;
                endcase
            end
        end
    end

    // Watchdog on transfer activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, no transfer for %0d cycles", $time,
                         WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result-side ready, with long hold-offs on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [31:0]           key_pool [$];
        logic [31:0]           kw;
        logic [LC_W-1:0]       lc;
        logic [APB_DATA_W-1:0] cfg_word;
        logic [LC_W-1:0]       corner_lc [4];
        request_t              req;
        int                    pool_size;

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACTION_GET;
        sh_line_count = LINE_COUNT_RESET;
        clear_shadow();
        corner_lc = '{5'd1, 5'd16, 5'd0, 5'd31};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        add_checked(ACTION_GET, 16'h0000, 16'h0000, 64'h0, ST_GET_MISS, 4'd0, 64'h0, 5'd0);
        add_checked(ACTION_PUT, 16'h0000, 16'h0000, 64'h0, ST_PUT_FILL, 4'd0, 64'h0, 5'd1);
        add_checked(ACTION_GET, 16'h0000, 16'h0000, 64'h0, ST_GET_HIT, 4'd0, 64'h0, 5'd1);
        add_checked(ACTION_PUT, 16'hFFFF, 16'hFFFF, '1, ST_PUT_FILL, 4'd1, 64'h0, 5'd2);
        add_checked(ACTION_GET, 16'hFFFF, 16'hFFFF, 64'h0, ST_GET_HIT, 4'd1, '1, 5'd2);
        // get ignores its payload; a half-matching all-ones key must miss
        add_checked(ACTION_GET, 16'hFFFF, 16'h0000, '1, ST_GET_MISS, 4'd0, 64'h0, 5'd2);
        add_checked(ACTION_PUT, 16'hFFFF, 16'hFFFF, 64'hA5A5_A5A5_A5A5_A5A5,
                    ST_PUT_UPD, 4'd1, 64'h0, 5'd2);
        add_req(ACTION_GET, 16'h0000, 16'hFFFF, 64'h0);
        add_cfg(ADDR_UNMAPPED, 32'd1);
        add_checked(ACTION_GET, 16'hFFFF, 16'hFFFF, 64'h0, ST_GET_HIT, 4'd1,
                    64'hA5A5_A5A5_A5A5_A5A5, 5'd2);
        add_cfg(ADDR_LINE_COUNT, 32'd0);    // zero behaves as one line
        add_checked(ACTION_GET, 16'h0000, 16'h0000, 64'h0, ST_GET_MISS, 4'd0, 64'h0, 5'd0);
        add_checked(ACTION_PUT, 16'h0001, 16'h0001, 64'h1, ST_PUT_FILL, 4'd0, 64'h0, 5'd1);
        add_checked(ACTION_PUT, 16'h0002, 16'h0002, 64'h2, ST_PUT_REPL, 4'd0, 64'h0, 5'd1);
        add_checked(ACTION_GET, 16'h0001, 16'h0001, 64'h0, ST_GET_MISS, 4'd0, 64'h0, 5'd1);
        add_req(ACTION_GET, 16'h0002, 16'h0002, 64'h0);
        add_cfg(ADDR_LINE_COUNT, 32'd31);   // clamps to the built line count
        add_checked(ACTION_PUT, 16'h0003, 16'h0003, 64'h3, ST_PUT_FILL, 4'd0, 64'h0, 5'd1);
        add_cfg(ADDR_LINE_COUNT, 32'd2);
        add_req(ACTION_PUT, 16'h000A, 16'h000A, 64'hA);
        add_req(ACTION_PUT, 16'h000B, 16'h000B, 64'hB);
        add_req(ACTION_GET, 16'h000A, 16'h000A, 64'h0);
        add_req(ACTION_PUT, 16'h000C, 16'h000C, 64'hC);
        add_req(ACTION_GET, 16'h000B, 16'h000B, 64'h0);
        add_cfg(ADDR_LINE_COUNT, 32'hFFFF_FFE3);   // upper bits dropped
        add_req(ACTION_PUT, 16'h8000, 16'h0001, 64'h8000_0000_0000_0001);
        add_req(ACTION_GET, 16'h8000, 16'h0001, 64'h0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_for_drain();
                apb_write(dir_rows[i].addr, dir_rows[i].value);
                settings_seen++;
            end
            else
                send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random phases
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES / 3)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 21;
            end
            else if (ph == 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_for_drain();
            if (ph < 4)
                lc = corner_lc[ph];
            else if ($urandom_range(1) == 1)
                lc = LC_W'($urandom_range(1, 6));
            else
                lc = LC_W'($urandom_range(0, 31));
            if ($urandom_range(3) == 0)
                apb_write(ADDR_UNMAPPED, $urandom);
            cfg_word = $urandom;
            cfg_word[LC_W-1:0] = lc;
            if ($urandom_range(1) == 1)
                cfg_word[APB_DATA_W-1:LC_W] = '0;
            apb_write(ADDR_LINE_COUNT, cfg_word);
            settings_seen++;

            // small key pool: a few more keys than lines, so the LRU is exercised
            key_pool.delete();
            pool_size = active_count(lc) + $urandom_range(1, 3);
            for (int k = 0; k < pool_size; k++)
            begin
                kw = $urandom;
                if ($urandom_range(9) == 0)
                    kw[15:0] = 16'hFFFF;
                if ($urandom_range(9) == 0)
                    kw[31:16] = 16'hFFFF;
                key_pool.push_back(kw);
            end

            if (ph == 3)
                hold_requests++;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 8 && k == PHASE_ITEMS / 2)
                    wait_for_drain();
                if ($urandom_range(99) < 88)
                    kw = key_pool[$urandom_range(pool_size - 1)];
                else
                    kw = $urandom;
                req.action  = ($urandom_range(1) == 1) ? ACTION_PUT : ACTION_GET;
                req.track   = kw[15:0];
                req.sector  = kw[31:16];
                req.payload = {$urandom, $urandom};
                case ($urandom_range(15))
                    0:       req.payload = '1;
                    1:       req.payload = '0;
                    default: ;
                endcase
                send_request(req, 1'b0, '0);
            end
        end

        wait_for_drain();
        if (pending_results.size() != 0)
            report_mismatch("results left over", 64'(pending_results.size()), 64'(0));

        $display("Run covered %0d requests under %0d register settings", requests_sent,
                 settings_seen);
        $display("get hits %0d, get misses %0d, updates %0d, fills %0d, replacements %0d",
                 n_hit, n_miss, n_upd, n_fill, n_repl);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* lru_sector_cache.f */
rtl/lsc_pkg.sv
rtl/lsc_cfg.sv
rtl/lsc_ctrl.sv
rtl/lsc_datapath.sv
rtl/lru_sector_cache.sv
test/tb_lru_sector_cache.sv
